>>> sv/dnle_pkg.sv
// Shared constants and types for the DNS name label encoder.
package dnle_pkg;

   localparam int LABEL_MAX  = 62;
   localparam int LABEL_AW   = $clog2(LABEL_MAX);
   localparam int CNT_W      = 6;

   localparam logic [7:0] DOT_CHAR = 8'h2E;
   localparam logic [7:0] END_CHAR = 8'h00;

   localparam int INQ_DEPTH  = 2;
   localparam int INQ_AW     = $clog2(INQ_DEPTH);
   localparam int INQ_CW     = $clog2(INQ_DEPTH + 1);

   localparam int OUTQ_DEPTH = 4;
   localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_CHAR = 2'd0,
      KIND_DOT  = 2'd1,
      KIND_END  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] char_byte;
   } item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
      logic       label_error;
   } result_type;

endpackage

>>> sv/dnle_ram.sv
// Generic single-port-write, registered-read RAM.
module dnle_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 64,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/dnle_front.sv
// Front end: classifies incoming characters and queues them for the back end.
module dnle_front
   import dnle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] char_byte,
   output logic       item_valid,
   output item_type   item,
   input  logic       item_pop
);

   item_type             entry_ff [INQ_DEPTH];
   logic [INQ_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [INQ_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [INQ_CW-1:0]    count_ff, count_in;
   logic                 do_push, do_pop;
   item_type             new_item;

   always_comb begin
      new_item.char_byte = char_byte;
      priority if (char_byte == DOT_CHAR) begin
         new_item.kind = KIND_DOT;
      end else if (char_byte == END_CHAR) begin
         new_item.kind = KIND_END;
      end else begin
         new_item.kind = KIND_CHAR;
      end
   end

   assign full       = (count_ff == INQ_CW'(INQ_DEPTH));
   assign do_push    = push && !full;
   assign item_valid = (count_ff != '0);
   assign do_pop     = item_pop && item_valid;
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? INQ_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? INQ_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = INQ_CW'(count_ff + INQ_CW'(do_push) - INQ_CW'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

>>> sv/dnle_back.sv
// Back end: label store, flush sequencer and result staging.
module dnle_back
   import dnle_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   input  item_type           item,
   output logic               item_pop,
   input  logic [OUTQ_CW-1:0] outq_count,
   output logic               res_push,
   output result_type         res
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_LEN  = 4'b0010,
      ST_DATA = 4'b0100,
      ST_TERM = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic [LABEL_AW-1:0] idx_ff, idx_in;
   logic                is_end_ff, is_end_in;
   logic                err_ff, err_in;

   logic                stg_valid_ff, stg_valid_in;
   logic                stg_from_ram_ff, stg_from_ram_in;
   logic [7:0]          stg_byte_ff, stg_byte_in;
   logic                stg_last_ff, stg_last_in;
   logic                stg_err_ff, stg_err_in;

   logic                ram_we, ram_re;
   logic [7:0]          ram_rdata;
   logic [OUTQ_CW-1:0]  occupancy;
   logic                credit;

   // Reserve a queue slot for the request sitting in the staging register.
   assign occupancy = OUTQ_CW'(outq_count + OUTQ_CW'(stg_valid_ff));
   assign credit    = (occupancy < OUTQ_CW'(OUTQ_DEPTH));

   always_comb begin
      state_in        = state_ff;
      count_in        = count_ff;
      ovf_in          = ovf_ff;
      idx_in          = idx_ff;
      is_end_in       = is_end_ff;
      err_in          = err_ff;
      stg_valid_in    = 1'b0;
      stg_from_ram_in = stg_from_ram_ff;
      stg_byte_in     = stg_byte_ff;
      stg_last_in     = stg_last_ff;
      stg_err_in      = stg_err_ff;
      item_pop        = 1'b0;
      ram_we          = 1'b0;
      ram_re          = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               unique case (item.kind)
                  KIND_CHAR: begin
                     if (count_ff < CNT_W'(LABEL_MAX)) begin
                        ram_we   = 1'b1;
                        count_in = CNT_W'(count_ff + 1'b1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  KIND_DOT: begin
                     is_end_in = 1'b0;
                     state_in  = ST_LEN;
                  end
                  KIND_END: begin
                     is_end_in = 1'b1;
                     state_in  = ST_LEN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LEN: begin
            if (credit) begin
               stg_valid_in    = 1'b1;
               stg_from_ram_in = 1'b0;
               stg_byte_in     = 8'(count_ff);
               stg_last_in     = 1'b0;
               stg_err_in      = ovf_ff;
               err_in          = ovf_ff;
               idx_in          = '0;
               if (count_ff == '0) begin
                  ovf_in   = 1'b0;
                  state_in = is_end_ff ? ST_TERM : ST_IDLE;
               end else begin
                  state_in = ST_DATA;
               end
            end
         end
         ST_DATA: begin
            if (credit) begin
               ram_re          = 1'b1;
               stg_valid_in    = 1'b1;
               stg_from_ram_in = 1'b1;
               stg_last_in     = 1'b0;
               stg_err_in      = err_ff;
               idx_in          = LABEL_AW'(idx_ff + 1'b1);
               if (CNT_W'(idx_ff) == CNT_W'(count_ff - 1'b1)) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = is_end_ff ? ST_TERM : ST_IDLE;
               end
            end
         end
         ST_TERM: begin
            if (credit) begin
               stg_valid_in    = 1'b1;
               stg_from_ram_in = 1'b0;
               stg_byte_in     = END_CHAR;
               stg_last_in     = 1'b1;
               stg_err_in      = 1'b0;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         stg_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff          <= idx_in;
      is_end_ff       <= is_end_in;
      err_ff          <= err_in;
      stg_from_ram_ff <= stg_from_ram_in;
      stg_byte_ff     <= stg_byte_in;
      stg_last_ff     <= stg_last_in;
      stg_err_ff      <= stg_err_in;
   end

   dnle_ram #(
      .WIDTH (8),
      .DEPTH (LABEL_MAX)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (LABEL_AW'(count_ff)),
      .wr_data (item.char_byte),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign res_push        = stg_valid_ff;
   assign res.out_byte    = stg_from_ram_ff ? ram_rdata : stg_byte_ff;
   assign res.last_byte   = stg_last_ff;
   assign res.label_error = stg_err_ff;

endmodule

>>> sv/dnle_outq.sv
// Result queue between the back end and the rsp_ ports.
module dnle_outq
   import dnle_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               res_push,
   input  result_type         res,
   output logic [OUTQ_CW-1:0] count,
   output logic               empty,
   input  logic               pop,
   output result_type         head
);

   result_type          entry_ff [OUTQ_DEPTH];
   logic [OUTQ_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [OUTQ_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [OUTQ_CW-1:0]  count_ff, count_in;
   logic                do_pop;

   assign empty  = (count_ff == '0);
   assign count  = count_ff;
   assign do_pop = pop && !empty;
   assign head   = entry_ff[rd_ptr_ff];

   // The back end never pushes without a free slot.
   always_comb begin
      wr_ptr_in = res_push ? OUTQ_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop   ? OUTQ_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = OUTQ_CW'(count_ff + OUTQ_CW'(res_push) - OUTQ_CW'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_push) begin
         entry_ff[wr_ptr_ff] <= res;
      end
   end

endmodule

>>> sv/dns_name_label_encoder.sv
// DNS name label encoder: dotted host name in, DNS wire-format labels out.
//
// Input channel: one name character per request on req_char_byte, taken when
// push is high and full is low. A dot ends a label, a zero byte ends the name.
// Result channel: while empty is low the oldest result sits on rsp_out_byte,
// rsp_last_byte and rsp_label_error; pop high with empty low takes it.
// A label is sent as its length byte and then its characters; the name ends
// with a zero byte marked rsp_last_byte. Labels over 62 characters are cut to
// 62 and every byte of that label carries rsp_label_error.
// Each ordinary character goes into the label RAM as the back end takes it,
// so the back end is free for the next request. A dot starts the single
// flush sequencer: the length byte, then label RAM reads one byte a cycle
// while the result queue has room; a zero byte adds the closing zero byte.
// Each result passes the staging register and the result queue. A two-entry
// request queue and a four-entry result queue let characters keep arriving.
// If pop stays low the result queue fills, the sequencer holds, the request
// queue fills and full rises; nothing is dropped.
// Synchronous reset empties both queues and clears the label state; no
// clearing pass is needed.
module dns_name_label_encoder
   import dnle_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_char_byte,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_last_byte,
   output logic       rsp_label_error
);

   logic               item_valid;
   item_type           item;
   logic               item_pop;
   logic [OUTQ_CW-1:0] outq_count;
   logic               res_push;
   result_type         res;
   result_type         head;

   dnle_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .char_byte  (req_char_byte),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop)
   );

   dnle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_pop   (item_pop),
      .outq_count (outq_count),
      .res_push   (res_push),
      .res        (res)
   );

   dnle_outq u_outq (
      .clock    (clock),
      .reset    (reset),
      .res_push (res_push),
      .res      (res),
      .count    (outq_count),
      .empty    (empty),
      .pop      (pop),
      .head     (head)
   );

   assign rsp_out_byte    = head.out_byte;
   assign rsp_last_byte   = head.last_byte;
   assign rsp_label_error = head.label_error;

endmodule
